[hdl/bhlc_pkg.sv]
// bhlc_pkg: types, codes and lookup functions for the button hold level classifier
// no dependencies; imported by every module of the block

package bhlc_pkg;

	localparam int unsigned LevelW  = 4;
	localparam int unsigned NwkW    = 3;
	localparam int unsigned EventW  = 3;
	localparam int unsigned ReqW    = 2;
	localparam int unsigned HoldW   = 16;
	localparam int unsigned CfgIdxW = 2;

	// request kinds
	localparam logic [ReqW-1:0] REQ_TICK    = 2'd0;
	localparam logic [ReqW-1:0] REQ_PRESS   = 2'd1;
	localparam logic [ReqW-1:0] REQ_RELEASE = 2'd2;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_FIRST  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_SECOND = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_THIRD  = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_FOURTH = 2'd3;

	// threshold reset values
	localparam logic [HoldW-1:0] FIRST_HOLD_RST  = 16'd1800;
	localparam logic [HoldW-1:0] SECOND_HOLD_RST = 16'd1200;
	localparam logic [HoldW-1:0] THIRD_HOLD_RST  = 16'd2000;
	localparam logic [HoldW-1:0] FOURTH_HOLD_RST = 16'd10000;

	// network states
	localparam logic [NwkW-1:0] NWK_IDLE         = 3'd0;
	localparam logic [NwkW-1:0] NWK_SCANNING     = 3'd1;
	localparam logic [NwkW-1:0] NWK_AUTO_JOINING = 3'd2;
	localparam logic [NwkW-1:0] NWK_JOINING      = 3'd3;
	localparam logic [NwkW-1:0] NWK_CONNECTED    = 3'd4;
	localparam logic [NwkW-1:0] NWK_DISCOVERABLE = 3'd5;

	// system events
	localparam logic [EventW-1:0] EVT_NONE        = 3'd0;
	localparam logic [EventW-1:0] EVT_POWER_ON    = 3'd1;
	localparam logic [EventW-1:0] EVT_POWER_OFF   = 3'd2;
	localparam logic [EventW-1:0] EVT_PAIRING     = 3'd3;
	localparam logic [EventW-1:0] EVT_SWITCH_ROLE = 3'd4;

	// levels with a meaning of their own
	localparam logic [LevelW-1:0] LVL_PRESS      = 4'd1;
	localparam logic [LevelW-1:0] LVL_LONG       = 4'd3;
	localparam logic [LevelW-1:0] LVL_VERY_LONG  = 4'd5;
	localparam logic [LevelW-1:0] LVL_VV_LONG    = 4'd7;
	localparam logic [LevelW-1:0] LVL_LAST_TIMED = 4'd9;

	typedef struct packed {
		logic [HoldW-1:0] first_hold_ms;
		logic [HoldW-1:0] second_hold_ms;
		logic [HoldW-1:0] third_hold_ms;
		logic [HoldW-1:0] fourth_hold_ms;
	} hold_cfg_t;

	typedef struct packed {
		logic [EventW-1:0] system_event;
		logic [LevelW-1:0] hold_level;
	} result_t;

	function automatic logic [EventW-1:0] lookup_event(
		input logic [NwkW-1:0]   nwk,
		input logic [LevelW-1:0] lvl
	);
		logic [EventW-1:0] evt;
		evt = EVT_NONE;
		case (lvl)
			LVL_LONG: begin
				if (nwk == NWK_IDLE)
					evt = EVT_POWER_ON;
				else if (nwk <= NWK_DISCOVERABLE)
					evt = EVT_POWER_OFF;
			end
			LVL_VERY_LONG: begin
				if (nwk == NWK_AUTO_JOINING || nwk == NWK_JOINING || nwk == NWK_CONNECTED)
					evt = EVT_PAIRING;
			end
			LVL_VV_LONG: begin
				if (nwk == NWK_IDLE)
					evt = EVT_SWITCH_ROLE;
			end
			default: evt = EVT_NONE;
		endcase
		return evt;
	endfunction

	// threshold loaded after reaching a press level
	function automatic logic [HoldW-1:0] next_threshold(
		input hold_cfg_t         cfg,
		input logic [LevelW-1:0] lvl
	);
		logic [HoldW-1:0] thr;
		case (lvl)
			LVL_PRESS:     thr = cfg.first_hold_ms;
			LVL_LONG:      thr = cfg.second_hold_ms;
			LVL_VERY_LONG: thr = cfg.third_hold_ms;
			default:       thr = cfg.fourth_hold_ms;
		endcase
		return thr;
	endfunction

endpackage

[hdl/bhlc_regs.sv]
// bhlc_regs: the four hold threshold registers behind the plain write port
// depends on bhlc_pkg

module bhlc_regs
	import bhlc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [HoldW-1:0]   cfg_data,
	output hold_cfg_t          cfg
);

	hold_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_hold_ms  <= FIRST_HOLD_RST;
			cfg_q.second_hold_ms <= SECOND_HOLD_RST;
			cfg_q.third_hold_ms  <= THIRD_HOLD_RST;
			cfg_q.fourth_hold_ms <= FOURTH_HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST:  cfg_q.first_hold_ms  <= cfg_data;
				CFG_SECOND: cfg_q.second_hold_ms <= cfg_data;
				CFG_THIRD:  cfg_q.third_hold_ms  <= cfg_data;
				CFG_FOURTH: cfg_q.fourth_hold_ms <= cfg_data;
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/bhlc_core.sv]
// bhlc_core: level, hold timer and run flag; updates them per request and forms the report
// depends on bhlc_pkg

module bhlc_core
	import bhlc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  hold_cfg_t        cfg,
	input  logic             req_valid,
	input  logic [ReqW-1:0]  req_type,
	input  logic [NwkW-1:0]  network_state,
	output logic             res_valid,
	output result_t          res
);

	logic [LevelW-1:0] level_q;
	logic [HoldW-1:0]  timer_q;
	logic              running_q;

	logic [LevelW-1:0] level_d;
	logic [HoldW-1:0]  timer_d;
	logic              running_d;
	logic [LevelW-1:0] rep_level;
	logic [LevelW-1:0] up_level;

	always_comb begin
		level_d   = level_q;
		timer_d   = timer_q;
		running_d = running_q;
		res_valid = 1'b0;
		rep_level = level_q;
		up_level  = level_q + LevelW'(2);
		if (req_valid) begin
			case (req_type)
				REQ_PRESS: begin
					level_d   = LVL_PRESS;
					timer_d   = next_threshold(cfg, LVL_PRESS);
					running_d = 1'b1;
					rep_level = LVL_PRESS;
					res_valid = 1'b1;
				end
				REQ_RELEASE: begin
					level_d   = '0;
					timer_d   = '0;
					running_d = 1'b0;
					rep_level = level_q + LevelW'(1);
					res_valid = 1'b1;
				end
				REQ_TICK: begin
					if (running_q) begin
						if (timer_q > HoldW'(1)) begin
							timer_d = timer_q - HoldW'(1);
						end else begin
							// expiry; a zero threshold behaves as one
							level_d   = up_level;
							rep_level = up_level;
							res_valid = 1'b1;
							if (up_level >= LVL_LAST_TIMED) begin
								running_d = 1'b0;
								timer_d   = '0;
							end else begin
								timer_d = next_threshold(cfg, up_level);
							end
						end
					end
				end
				default: res_valid = 1'b0;
			endcase
		end
		res.hold_level   = rep_level;
		res.system_event = lookup_event(network_state, rep_level);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '0;
			timer_q   <= '0;
			running_q <= 1'b0;
		end else begin
			level_q   <= level_d;
			timer_q   <= timer_d;
			running_q <= running_d;
		end
	end

endmodule

[hdl/bhlc_out.sv]
// bhlc_out: result register with a skid entry, decouples the report stream from stalls
// depends on bhlc_pkg

module bhlc_out
	import bhlc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q;
	result_t out_data_q;
	logic    skid_valid_q;
	result_t skid_data_q;
	logic    can_load;

	assign can_load = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				// no push can arrive while the skid entry is full
				if (can_load) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (can_load)
					out_valid_q <= 1'b1;
				else
					skid_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (can_load)
				out_data_q <= skid_data_q;
		end else if (push) begin
			if (can_load)
				out_data_q <= push_data;
			else
				skid_data_q <= push_data;
		end
	end

	assign room      = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[hdl/button_hold_level_classifier_top.sv]
// button_hold_level_classifier_top: top level of the button hold level classifier
// depends on bhlc_pkg, bhlc_regs, bhlc_core, bhlc_out

// Usage
//  s_* carries requests: s_tuser is the request kind (tick, press, release),
//  s_tdata the current network state. Ticks are one per millisecond.
//  m_* carries reports: hold level and the system event that goes with it.
//  A press reports level 1, each timer expiry reports the next odd level
//  (3, 5, 7, 9), a release reports level + 1. Ticks that do not expire the
//  timer, ticks while stopped and unknown kinds give no report.
//  Throughput: one request per cycle while s_tready is high; the state
//  update is a single pass between the state registers, the report sits
//  in a result register that drives m_tvalid and m_tdata.
//  A skid entry behind the result register lets s_tready stay high while
//  one report waits; s_tready drops only when both entries are full, i.e.
//  after the receiver has stalled with two reports pending.
//  Reset (arst_n low) clears level, timer and run flag, empties the report
//  buffer and loads the thresholds with 1800, 1200, 2000 and 10000 ms.
//  Thresholds are written through cfg_we/cfg_index/cfg_data while idle.

module button_hold_level_classifier_top
	import bhlc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [HoldW-1:0]   cfg_data,
	// request stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [2:0] network_state, rest zero
	input  logic [ReqW-1:0]    s_tuser,   // [1:0] req_type
	// report stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata    // [3:0] hold_level, [6:4] system_event, [7] zero
);

	hold_cfg_t cfg;
	logic      accept;
	logic      room;
	logic      res_valid;
	result_t   res;
	result_t   out_data;

	// a request is taken whenever the report buffer has a free entry
	assign s_tready = room;
	assign accept   = s_tvalid && room;

	bhlc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bhlc_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.req_valid     (accept),
		.req_type      (s_tuser),
		.network_state (s_tdata[NwkW-1:0]),
		.res_valid     (res_valid),
		.res           (res)
	);

	bhlc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data)
	);

	// pack report fields, lowest first, pad to a byte
	assign m_tdata = {1'b0, out_data.system_event, out_data.hold_level};

endmodule

[bench/button_hold_level_classifier_top_test.sv]
// button_hold_level_classifier_top_test: self-checking bench for the hold level classifier
// drives requests and thresholds, predicts every report and compares it field by field
// depends on bhlc_pkg and button_hold_level_classifier_top

module button_hold_level_classifier_top_test;
	import bhlc_pkg::*;

	// request kind with no meaning, the block must ignore it
	localparam logic [ReqW-1:0] REQ_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [ReqW-1:0] kind;
		logic [NwkW-1:0] nwk;
	} button_req_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [HoldW-1:0]   cfg_data  = '0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata   = '0;   // [2:0] network_state, rest zero
	logic [ReqW-1:0]    s_tuser   = '0;   // [1:0] req_type
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [7:0]         m_tdata;          // [3:0] hold_level, [6:4] system_event, [7] zero

	button_hold_level_classifier_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// requests waiting to be driven, reports waiting to arrive
	button_req_t pending_requests [$];
	result_t     expected_reports [$];

	// shadow copy of the classifier: thresholds, level, hold timer, run flag
	logic [HoldW-1:0]  hold_ms [4];
	logic [LevelW-1:0] cur_level = '0;
	logic [HoldW-1:0]  hold_left = '0;
	bit                hold_run  = 1'b0;

	int mismatches = 0;

	// handshake bookkeeping shared between the edge blocks
	bit          req_taken  = 1'b0;
	bit          req_on_bus = 1'b0;
	bit          req_burst  = 1'b0;
	int          req_wait   = 0;
	button_req_t next_req;
	bit          rpt_taken  = 1'b0;
	bit          rpt_burst  = 1'b0;
	int          rpt_stall  = 0;

	initial begin
		hold_ms[CFG_FIRST]  = FIRST_HOLD_RST;
		hold_ms[CFG_SECOND] = SECOND_HOLD_RST;
		hold_ms[CFG_THIRD]  = THIRD_HOLD_RST;
		hold_ms[CFG_FOURTH] = FOURTH_HOLD_RST;
	end

	task automatic report_mismatch(string what);
		$display("%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	// system event that goes with a reported level in a given network state
	function automatic logic [EventW-1:0] event_for(logic [NwkW-1:0] nwk, logic [LevelW-1:0] lvl);
		if (nwk > NWK_DISCOVERABLE)
			return EVT_NONE;
		if (lvl == LVL_LONG)
			return (nwk == NWK_IDLE) ? EVT_POWER_ON : EVT_POWER_OFF;
		if (lvl == LVL_VERY_LONG && nwk >= NWK_AUTO_JOINING && nwk <= NWK_CONNECTED)
			return EVT_PAIRING;
		if (lvl == LVL_VV_LONG && nwk == NWK_IDLE)
			return EVT_SWITCH_ROLE;
		return EVT_NONE;
	endfunction

	// hold time that starts once a press level has been reached
	function automatic logic [HoldW-1:0] hold_after(logic [LevelW-1:0] lvl);
		case (lvl)
			LVL_PRESS:     return hold_ms[CFG_FIRST];
			LVL_LONG:      return hold_ms[CFG_SECOND];
			LVL_VERY_LONG: return hold_ms[CFG_THIRD];
			default:       return hold_ms[CFG_FOURTH];
		endcase
	endfunction

	task automatic expect_report(logic [NwkW-1:0] nwk, logic [LevelW-1:0] lvl);
		result_t r;
		r.hold_level   = lvl;
		r.system_event = event_for(nwk, lvl);
		expected_reports.push_back(r);
	endtask

	// advance the shadow state by one accepted request
	task automatic predict_request(logic [ReqW-1:0] kind, logic [NwkW-1:0] nwk);
		logic [LevelW-1:0] released;
		case (kind)
			REQ_PRESS: begin
				// a press while held restarts the hold as well
				cur_level = LVL_PRESS;
				hold_left = hold_after(LVL_PRESS);
				hold_run  = 1'b1;
				expect_report(nwk, cur_level);
			end
			REQ_RELEASE: begin
				// release while idle reports level 1, release at 9 reports 10
				released  = cur_level + 1'b1;
				hold_run  = 1'b0;
				hold_left = '0;
				cur_level = '0;
				expect_report(nwk, released);
			end
			REQ_TICK: begin
				if (hold_run) begin
					if (hold_left > 1) begin
						hold_left = hold_left - 1'b1;
					end else begin
						// a timer found at 0 (threshold written as 0) expires too
						cur_level = cur_level + 4'd2;
						if (cur_level >= LVL_LAST_TIMED) begin
							hold_run  = 1'b0;
							hold_left = '0;
						end else begin
							hold_left = hold_after(cur_level);
						end
						expect_report(nwk, cur_level);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_report(logic [7:0] data);
		result_t want;
		logic [LevelW-1:0] got_level;
		logic [EventW-1:0] got_event;
		got_level = data[LevelW-1:0];
		got_event = data[LevelW+EventW-1:LevelW];
		if (expected_reports.size() == 0) begin
			report_mismatch($sformatf("report with none expected: level %0d event %0d",
				got_level, got_event));
		end else begin
			want = expected_reports.pop_front();
			if (got_level !== want.hold_level)
				report_mismatch($sformatf("hold_level %0d, expected %0d",
					got_level, want.hold_level));
			if (got_event !== want.system_event)
				report_mismatch($sformatf("system_event %0d, expected %0d (level %0d)",
					got_event, want.system_event, want.hold_level));
		end
	endtask

	// both handshakes are sampled at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				rpt_taken = 1'b1;
				check_report(m_tdata);
			end
			if (s_tvalid && s_tready) begin
				req_taken = 1'b1;
				predict_request(s_tuser, s_tdata[NwkW-1:0]);
			end
		end
	end

	// request driver: one request on the bus at a time, random gap after each,
	// now and then switching into or out of a run with no gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_taken) begin
				req_taken  = 1'b0;
				req_on_bus = 1'b0;
				if ($urandom_range(0, 39) == 0)
					req_burst = !req_burst;
				req_wait = req_burst ? 0 : $urandom_range(0, 5);
			end
			if (!req_on_bus) begin
				if (req_wait > 0) begin
					req_wait--;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					next_req = pending_requests.pop_front();
					s_tuser  <= next_req.kind;
					s_tdata  <= {{(8 - NwkW){1'b0}}, next_req.nwk};
					s_tvalid <= 1'b1;
					req_on_bus = 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// report receiver: holds tready low for a random stall after each report
	always @(negedge clk) begin
		if (arst_n) begin
			if (rpt_taken) begin
				rpt_taken = 1'b0;
				if ($urandom_range(0, 39) == 0)
					rpt_burst = !rpt_burst;
				rpt_stall = rpt_burst ? 0 : $urandom_range(0, 5);
			end
			if (rpt_stall > 0) begin
				rpt_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [NwkW-1:0] any_nwk();
		return NwkW'($urandom_range(0, 7));
	endfunction

	task automatic queue_req(logic [ReqW-1:0] kind, logic [NwkW-1:0] nwk);
		button_req_t r;
		r.kind = kind;
		r.nwk  = nwk;
		pending_requests.push_back(r);
	endtask

	// press followed by a run of ticks in random network states
	task automatic queue_long_hold(logic [NwkW-1:0] nwk, int ticks);
		queue_req(REQ_PRESS, nwk);
		repeat (ticks) queue_req(REQ_TICK, any_nwk());
	endtask

	// mostly press / ticks / release sequences sized to the current thresholds,
	// mixed with stray requests of any kind; stray unknown kinds and unheld ticks are not counted
	task automatic queue_random(int count);
		int made;
		int span;
		int ticks;
		bit held;
		logic [ReqW-1:0] kind;
		made = 0;
		held = 1'b0;
		while (made < count) begin
			if ($urandom_range(0, 9) < 8) begin
				queue_req(REQ_PRESS, any_nwk());
				span = 3;
				for (int i = 0; i < 4; i++)
					span += (hold_ms[i] == 0) ? 1 : int'(hold_ms[i]);
				ticks = $urandom_range(0, (span > 60) ? 60 : span);
				repeat (ticks) queue_req(REQ_TICK, any_nwk());
				made += ticks + 1;
				held = 1'b1;
				if ($urandom_range(0, 7) != 0) begin
					queue_req(REQ_RELEASE, any_nwk());
					made++;
					held = 1'b0;
				end
			end else begin
				kind = ReqW'($urandom_range(0, 3));
				queue_req(kind, any_nwk());
				if (kind == REQ_PRESS || kind == REQ_RELEASE || (kind == REQ_TICK && held))
					made++;
				if (kind == REQ_PRESS)
					held = 1'b1;
				else if (kind == REQ_RELEASE)
					held = 1'b0;
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_requests.size() > 0 || req_on_bus || expected_reports.size() > 0)
			@(negedge clk);
		// a trailing tick gives no report, leave room for it to settle
		repeat (4) @(negedge clk);
	endtask

	task automatic write_threshold(logic [CfgIdxW-1:0] idx, logic [HoldW-1:0] ms);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= ms;
		hold_ms[idx] = ms;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [HoldW-1:0] t1, logic [HoldW-1:0] t2,
		logic [HoldW-1:0] t3, logic [HoldW-1:0] t4);
		write_threshold(CFG_FIRST, t1);
		write_threshold(CFG_SECOND, t2);
		write_threshold(CFG_THIRD, t3);
		write_threshold(CFG_FOURTH, t4);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset thresholds: a short hold that stays below the first expiry, then release
		queue_long_hold(NWK_IDLE, 40);
		queue_req(REQ_RELEASE, NWK_CONNECTED);   // level 2
		wait_idle();

		// shortest thresholds, directed walk over levels, events and odd cases
		write_all(16'd1, 16'd1, 16'd1, 16'd1);
		queue_req(REQ_RELEASE, NWK_IDLE);        // release while idle
		queue_req(REQ_UNKNOWN, NWK_SCANNING);    // unknown kind ignored
		queue_req(REQ_TICK, NWK_IDLE);           // tick while stopped
		queue_req(REQ_PRESS, 3'd7);
		queue_req(REQ_TICK, NWK_IDLE);           // level 3, power on
		queue_req(REQ_TICK, NWK_CONNECTED);      // level 5, pairing
		queue_req(REQ_TICK, NWK_IDLE);           // level 7, switch role
		queue_req(REQ_TICK, NWK_DISCOVERABLE);   // level 9
		queue_req(REQ_TICK, NWK_JOINING);        // no timeout after level 9
		queue_req(REQ_RELEASE, NWK_AUTO_JOINING); // level 10
		queue_req(REQ_PRESS, NWK_SCANNING);
		queue_req(REQ_TICK, NWK_SCANNING);       // level 3, power off
		queue_req(REQ_PRESS, NWK_AUTO_JOINING);  // press while held restarts
		queue_req(REQ_TICK, 3'd6);               // unknown network state, no event
		queue_req(REQ_TICK, NWK_AUTO_JOINING);   // level 5, pairing
		queue_req(REQ_TICK, NWK_JOINING);        // level 7, none
		queue_req(REQ_RELEASE, 3'd7);            // level 8
		queue_req(REQ_PRESS, NWK_DISCOVERABLE);
		queue_req(REQ_TICK, NWK_DISCOVERABLE);   // level 3, power off
		queue_req(REQ_RELEASE, NWK_JOINING);     // level 4
		queue_req(REQ_PRESS, NWK_IDLE);
		queue_req(REQ_TICK, NWK_JOINING);
		queue_req(REQ_TICK, NWK_SCANNING);       // level 5, none
		queue_req(REQ_RELEASE, NWK_IDLE);        // level 6
		queue_random(300);
		wait_idle();

		// thresholds of zero behave like one
		write_all(16'd0, 16'd0, 16'd0, 16'd0);
		queue_random(250);
		wait_idle();

		// small random thresholds
		repeat (2) begin
			write_all(HoldW'($urandom_range(1, 8)), HoldW'($urandom_range(1, 8)),
				HoldW'($urandom_range(1, 8)), HoldW'($urandom_range(1, 8)));
			queue_random(300);
			wait_idle();
		end

		// largest thresholds: a short hold well below the first expiry
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_long_hold(NWK_IDLE, 40);
		queue_req(REQ_RELEASE, NWK_SCANNING);
		queue_random(150);
		wait_idle();

		repeat (6) @(negedge clk);
		if (mismatches == 0)
			$display("button_hold_level_classifier_top_test: clean");
		else
			$display("button_hold_level_classifier_top_test: errors");
		$finish;
	end

	// hard stop well beyond the slowest passing run
	initial begin
		#60000000;
		$display("button_hold_level_classifier_top_test: errors");
		$finish;
	end

endmodule
